>>> sv/z80dma_pkg.sv
package z80dma_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam int NREGS = 28;

  localparam logic [4:0] I_RR0 = 5'd0;
  localparam logic [4:0] I_RR1 = 5'd1;
  localparam logic [4:0] I_RR2 = 5'd2;
  localparam logic [4:0] I_RR3 = 5'd3;
  localparam logic [4:0] I_RR4 = 5'd4;
  localparam logic [4:0] I_RR5 = 5'd5;
  localparam logic [4:0] I_RR6 = 5'd6;
  localparam logic [4:0] I_WR0 = 5'd7;
  localparam logic [4:0] I_WR1 = 5'd8;
  localparam logic [4:0] I_WR2 = 5'd9;
  localparam logic [4:0] I_WR3 = 5'd10;
  localparam logic [4:0] I_WR6 = 5'd13;
  localparam logic [4:0] I_AL = 5'd14;
  localparam logic [4:0] I_AH = 5'd15;
  localparam logic [4:0] I_LENL = 5'd16;
  localparam logic [4:0] I_LENH = 5'd17;
  localparam logic [4:0] I_TIMA = 5'd18;
  localparam logic [4:0] I_TIMB = 5'd19;
  localparam logic [4:0] I_MASK = 5'd20;
  localparam logic [4:0] I_MATCH = 5'd21;
  localparam logic [4:0] I_BL = 5'd22;
  localparam logic [4:0] I_BH = 5'd23;
  localparam logic [4:0] I_INTCTL = 5'd24;
  localparam logic [4:0] I_PULSE = 5'd25;
  localparam logic [4:0] I_VECTOR = 5'd26;
  localparam logic [4:0] I_RDMASK = 5'd27;

  localparam logic [7:0] CMD_RESET = 8'hC3;
  localparam logic [7:0] CMD_TIMA = 8'hC7;
  localparam logic [7:0] CMD_TIMB = 8'hCB;
  localparam logic [7:0] CMD_REINIT = 8'hCF;
  localparam logic [7:0] CMD_CLRCNT = 8'hD3;
  localparam logic [7:0] CMD_CLRB5 = 8'hAF;
  localparam logic [7:0] CMD_SETB5 = 8'hAB;
  localparam logic [7:0] CMD_SETEN = 8'hA3;
  localparam logic [7:0] CMD_EN2 = 8'hB7;
  localparam logic [7:0] CMD_RDST = 8'hBF;
  localparam logic [7:0] CMD_RDMSK = 8'hBB;
  localparam logic [7:0] CMD_RDINIT = 8'hA7;
  localparam logic [7:0] CMD_EN1 = 8'h87;
  localparam logic [7:0] CMD_DIS = 8'h83;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        transfer;
    logic [15:0] source_address;
    logic        source_is_io;
    logic [15:0] dest_address;
    logic        dest_is_io;
    logic [1:0]  cycles_taken;
    logic        block_done;
  } result_t;

  function automatic logic [15:0] step_addr(input logic [15:0] a, input logic [7:0] ctl);
    if (ctl[5]) return a;
    if (ctl[4]) return a + 16'd1;
    return a - 16'd1;
  endfunction

endpackage

>>> sv/z80dma_core.sv
module z80dma_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [1:0]          action,
  input  logic [7:0]          write_data,
  output z80dma_pkg::result_t res
);
  import z80dma_pkg::*;

  logic [7:0]  regs [NREGS];
  logic [7:0]  regs_next [NREGS];
  logic [7:0]  read_select_mask, read_select_mask_next;
  logic [27:0] write_follow_mask, write_follow_mask_next;
  logic [2:0]  read_index, read_index_next;
  logic [4:0]  write_index, write_index_next;
  logic [1:0]  enable_mode, enable_mode_next;
  logic [2:0]  wait_count, wait_count_next;

  logic [4:0]  pos;
  logic [7:0]  rot;
  logic [2:0]  roff;
  logic        rfound;
  logic [2:0]  ri;
  logic [3:0]  tsum;
  logic [15:0] a, b, cnt, a_st, b_st;
  logic [7:0]  rr5, rr6, cmd;
  logic [1:0]  sel;
  logic        clr;

  always_comb begin
    regs_next = regs;
    read_select_mask_next = read_select_mask;
    write_follow_mask_next = write_follow_mask;
    read_index_next = read_index;
    write_index_next = write_index;
    enable_mode_next = enable_mode;
    wait_count_next = wait_count;
    res = '0;
    clr = 1'b0;
    pos = '0;
    rot = '0;
    roff = '0;
    rfound = 1'b0;
    ri = '0;
    tsum = '0;
    a = '0; b = '0; cnt = '0; a_st = '0; b_st = '0;
    rr5 = regs[I_RR5];
    rr6 = regs[I_RR6];
    cmd = '0;
    sel = write_data[1:0];
    for (int i = NREGS - 1; i >= 0; i--) begin
      if (write_follow_mask[i]) pos = 5'(i);
    end
    unique case (action_t'(action))
      ACT_WRITE: begin
        if (write_follow_mask != '0) begin
          write_follow_mask_next[pos] = 1'b0;
          if (pos == I_INTCTL) begin
            if (write_data[4]) write_follow_mask_next[I_VECTOR] = 1'b1;
            if (write_data[3]) write_follow_mask_next[I_PULSE] = 1'b1;
          end
          regs_next[pos] = write_data;
          write_index_next = pos + 5'd1;
        end else begin
          write_follow_mask_next = '0;
          write_index_next = '0;
          if ((write_data & 8'h87) == 8'h04) begin
            regs_next[I_WR1] = write_data;
            write_follow_mask_next[I_TIMA] = write_data[6];
          end else if ((write_data & 8'h87) == 8'h00) begin
            regs_next[I_WR2] = write_data;
            write_follow_mask_next[I_TIMB] = write_data[6];
          end else if (!write_data[7]) begin
            regs_next[I_WR0] = write_data;
            write_follow_mask_next[I_LENH] = write_data[6];
            write_follow_mask_next[I_LENL] = write_data[5];
            write_follow_mask_next[I_AH] = write_data[4];
            write_follow_mask_next[I_AL] = write_data[3];
          end else begin
            regs_next[I_WR3 + 5'(sel)] = write_data;
            case (sel)
              2'd0: begin
                write_follow_mask_next[I_MATCH] = write_data[4];
                write_follow_mask_next[I_MASK] = write_data[3];
              end
              2'd1: begin
                write_follow_mask_next[I_INTCTL] = write_data[4];
                write_follow_mask_next[I_BH] = write_data[3];
                write_follow_mask_next[I_BL] = write_data[2];
              end
              2'd3: begin
                // command executes from the freshly written wr6
                cmd = write_data;
                unique case (cmd)
                  CMD_RESET: clr = 1'b1;
                  CMD_TIMA: regs_next[I_TIMA] = 8'd2;
                  CMD_TIMB: regs_next[I_TIMB] = 8'd2;
                  CMD_REINIT: begin
                    regs_next[I_RR0] = '0;
                    regs_next[I_RR1] = '0;
                    regs_next[I_RR2] = '0;
                    regs_next[I_RR3] = regs[I_AL];
                    regs_next[I_RR4] = regs[I_AH];
                  end
                  CMD_CLRCNT: begin
                    regs_next[I_RR1] = '0;
                    regs_next[I_RR2] = '0;
                  end
                  CMD_CLRB5: regs_next[I_WR3][5] = 1'b0;
                  CMD_SETB5: regs_next[I_WR3][5] = 1'b1;
                  CMD_SETEN: begin
                    regs_next[I_WR3][5] = 1'b1;
                    enable_mode_next = 2'd2;
                  end
                  CMD_EN2: enable_mode_next = 2'd2;
                  CMD_RDST: begin
                    read_select_mask_next = 8'd1;
                    read_index_next = '0;
                  end
                  CMD_RDMSK: begin
                    write_follow_mask_next = '0;
                    write_follow_mask_next[I_RDMASK] = 1'b1;
                  end
                  CMD_RDINIT: begin
                    read_index_next = '0;
                    read_select_mask_next = regs[I_RDMASK] & 8'h7F;
                  end
                  CMD_EN1: enable_mode_next = 2'd1;
                  CMD_DIS: enable_mode_next = 2'd0;
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
      end
      ACT_READ: begin
        res.read_data = 8'hFF;
        rot = (read_select_mask >> read_index) | (read_select_mask << (4'd8 - {1'b0, read_index}));
        for (int k = 7; k >= 0; k--) begin
          if (rot[k]) begin
            roff = 3'(k);
            rfound = 1'b1;
          end
        end
        if (rfound) begin
          ri = read_index + roff;
          read_select_mask_next[ri] = 1'b0;
          read_index_next = ri + 3'd1;
          res.read_data = regs[{2'b00, ri}];
        end
      end
      ACT_TICK: begin
        if (enable_mode != '0) begin
          if (wait_count != '0) begin
            wait_count_next = wait_count - 3'd1;
          end else begin
            tsum = {2'b00, regs[I_TIMA][1:0]} + {2'b00, regs[I_TIMB][1:0]};
            wait_count_next = (tsum >= 4'd4) ? 3'd0 : 3'(4'd4 - tsum);
            a = {regs[I_RR4], regs[I_RR3]};
            if (regs[I_WR2][5]) begin
              b = {regs[I_BH], regs[I_BL]};
            end else begin
              if ((regs[I_RR1] | regs[I_RR2]) == '0) begin
                rr5 = regs[I_BL];
                rr6 = regs[I_BH];
              end
              b = {rr6, rr5};
            end
            res.transfer = 1'b1;
            if (regs[I_WR0][2]) begin
              res.source_address = a; res.source_is_io = regs[I_WR1][3];
              res.dest_address = b;   res.dest_is_io = regs[I_WR2][3];
            end else begin
              res.source_address = b; res.source_is_io = regs[I_WR2][3];
              res.dest_address = a;   res.dest_is_io = regs[I_WR1][3];
            end
            res.cycles_taken = 2'd2;
            cnt = {regs[I_RR2], regs[I_RR1]} + 16'd1;
            regs_next[I_RR1] = cnt[7:0];
            regs_next[I_RR2] = cnt[15:8];
            a_st = step_addr(a, regs[I_WR1]);
            regs_next[I_RR3] = a_st[7:0];
            regs_next[I_RR4] = a_st[15:8];
            if (!regs[I_WR2][5]) begin
              b_st = step_addr(b, regs[I_WR2]);
              regs_next[I_RR5] = b_st[7:0];
              regs_next[I_RR6] = b_st[15:8];
            end
            if (cnt == {regs[I_LENH], regs[I_LENL]}) begin
              enable_mode_next = '0;
              regs_next[I_RR0][0] = 1'b1;
              res.block_done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (go && clr)) begin
      for (int i = 0; i < NREGS; i++) regs[i] <= '0;
      read_select_mask <= '0;
      write_follow_mask <= '0;
      read_index <= '0;
      write_index <= '0;
      enable_mode <= '0;
      wait_count <= '0;
    end else if (go) begin
      regs <= regs_next;
      read_select_mask <= read_select_mask_next;
      write_follow_mask <= write_follow_mask_next;
      read_index <= read_index_next;
      write_index <= write_index_next;
      enable_mode <= enable_mode_next;
      wait_count <= wait_count_next;
    end
  end

endmodule

>>> sv/z80_dma_controller.sv
// z80-style dma controller, block transfer subset
// command channel: start with action and write_data starts a transaction when
// busy is low; busy is never raised, so one transaction may start every cycle
// action 0 writes a control byte, 1 reads a status byte, 2 is one bus clock tick
// result: done pulses for one cycle, in the cycle after the start, with read_data,
// transfer, source/dest address and space, cycles_taken and block_done
// throughput 1 transaction per cycle; all state updates in the same single pass
// of logic between the command and the result register
// the receiver cannot stall; results must be taken in the cycle done is high
// rst (synchronous) clears the register file, masks, indices, enable and wait
// count; no clearing pass, the block is usable the cycle after reset
// the reset command (wr6 0xc3) clears the same state as rst
module z80_dma_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  write_data,
  output logic        done,
  output logic [7:0]  read_data,
  output logic        transfer,
  output logic [15:0] source_address,
  output logic        source_is_io,
  output logic [15:0] dest_address,
  output logic        dest_is_io,
  output logic [1:0]  cycles_taken,
  output logic        block_done
);
  import z80dma_pkg::*;

  result_t res, res_q;
  logic    go;

  // never blocks: every transaction finishes in one pass
  assign busy = 1'b0;
  assign go = start && !busy;

  z80dma_core u_core (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .action     (action),
    .write_data (write_data),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
    res_q <= res;
  end

  assign read_data = res_q.read_data;
  assign transfer = res_q.transfer;
  assign source_address = res_q.source_address;
  assign source_is_io = res_q.source_is_io;
  assign dest_address = res_q.dest_address;
  assign dest_is_io = res_q.dest_is_io;
  assign cycles_taken = res_q.cycles_taken;
  assign block_done = res_q.block_done;

endmodule

>>> sv/z80dma_checker.sv
module z80dma_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic        done,
  input logic        transfer,
  input logic [1:0]  cycles_taken,
  input logic        block_done,
  input logic [7:0]  read_data
);
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done) else $error("missing result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done) else $error("spurious result");
  a_cycles: assert property (@(posedge clk) disable iff (rst)
    done |-> (transfer ? cycles_taken == 2'd2 : cycles_taken == 2'd0))
    else $error("cycles mismatch");
  a_block: assert property (@(posedge clk) disable iff (rst)
    (done && block_done) |-> transfer) else $error("done without transfer");
  a_read: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action != 2'd1) |=> read_data == 8'd0)
    else $error("read data on non-read");
endmodule

bind z80_dma_controller z80dma_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .done(done),
  .transfer(transfer), .cycles_taken(cycles_taken), .block_done(block_done),
  .read_data(read_data)
);

>>> test/tb.sv
module tb;
  import z80dma_pkg::*;

  class dma_scoreboard;
    logic [7:0]  regs [NREGS];
    logic [7:0]  rd_mask;
    logic [27:0] wr_pending;
    logic [2:0]  rd_idx;
    logic [4:0]  wr_idx;
    logic [1:0]  en_mode;
    logic [2:0]  wait_cnt;
    result_t     pending_results[$];
    int          errors;
    int          n_results;
    int          n_moves;
    int          n_blocks;
    int          n_reads;

    function void clear_state();
      foreach (regs[i]) regs[i] = 8'd0;
      rd_mask    = 8'd0;
      wr_pending = 28'd0;
      rd_idx     = 3'd0;
      wr_idx     = 5'd0;
      en_mode    = 2'd0;
      wait_cnt   = 3'd0;
    endfunction

    function void exec_command(logic [7:0] c);
      case (c)
        CMD_RESET:  clear_state();
        CMD_TIMA:   regs[I_TIMA] = 8'd2;
        CMD_TIMB:   regs[I_TIMB] = 8'd2;
        CMD_REINIT: begin
          regs[I_RR0] = 8'd0;
          regs[I_RR1] = 8'd0;
          regs[I_RR2] = 8'd0;
          regs[I_RR3] = regs[I_AL];
          regs[I_RR4] = regs[I_AH];
        end
        CMD_CLRCNT: begin
          regs[I_RR1] = 8'd0;
          regs[I_RR2] = 8'd0;
        end
        CMD_CLRB5:  regs[I_WR3][5] = 1'b0;
        CMD_SETB5:  regs[I_WR3][5] = 1'b1;
        CMD_SETEN:  begin
          regs[I_WR3][5] = 1'b1;
          en_mode = 2'd2;
        end
        CMD_EN2:    en_mode = 2'd2;
        CMD_RDST:   begin
          rd_mask = 8'd1;
          rd_idx  = 3'd0;
        end
        CMD_RDMSK:  wr_pending = 28'd1 << I_RDMASK;
        CMD_RDINIT: begin
          rd_idx  = 3'd0;
          rd_mask = regs[I_RDMASK] & 8'h7F;
        end
        CMD_EN1:    en_mode = 2'd1;
        CMD_DIS:    en_mode = 2'd0;
        default: ;
      endcase
    endfunction

    function void write_ctrl(logic [7:0] v);
      int pos;
      if (wr_pending != 0) begin
        pos = 0;
        for (int i = NREGS - 1; i >= 0; i--) if (wr_pending[i]) pos = i;
        wr_pending[pos] = 1'b0;
        if (pos == I_INTCTL) begin
          if (v[4]) wr_pending[I_VECTOR] = 1'b1;
          if (v[3]) wr_pending[I_PULSE] = 1'b1;
        end
        regs[pos] = v;
        wr_idx = 5'(pos + 1);
        return;
      end
      wr_idx = 5'd0;
      if ((v & 8'h87) == 8'h04) begin
        regs[I_WR1] = v;
        if (v[6]) wr_pending[I_TIMA] = 1'b1;
      end else if ((v & 8'h87) == 8'h00) begin
        regs[I_WR2] = v;
        if (v[6]) wr_pending[I_TIMB] = 1'b1;
      end else if (!v[7]) begin
        regs[I_WR0] = v;
        if (v[6]) wr_pending[I_LENH] = 1'b1;
        if (v[5]) wr_pending[I_LENL] = 1'b1;
        if (v[4]) wr_pending[I_AH] = 1'b1;
        if (v[3]) wr_pending[I_AL] = 1'b1;
      end else begin
        regs[I_WR3 + v[1:0]] = v;
        case (v[1:0])
          2'd0: begin
            if (v[4]) wr_pending[I_MATCH] = 1'b1;
            if (v[3]) wr_pending[I_MASK] = 1'b1;
          end
          2'd1: begin
            if (v[4]) wr_pending[I_INTCTL] = 1'b1;
            if (v[3]) wr_pending[I_BH] = 1'b1;
            if (v[2]) wr_pending[I_BL] = 1'b1;
          end
          2'd3: exec_command(regs[I_WR6]);
          default: ;
        endcase
      end
    endfunction

    function logic [7:0] read_status();
      logic [2:0] i;
      if (rd_mask == 0) return 8'hFF;
      for (int k = 0; k < 8; k++) begin
        i = 3'(rd_idx + k);
        if (rd_mask[i]) begin
          rd_mask[i] = 1'b0;
          rd_idx = 3'(i + 1);
          return regs[i];
        end
      end
      return 8'hFF;
    endfunction

    function logic [15:0] next_addr(logic [15:0] a, logic [7:0] ctl);
      if (ctl[5]) return a;
      return ctl[4] ? a + 16'd1 : a - 16'd1;
    endfunction

    function void bus_tick(ref result_t r);
      logic [15:0] a, b, cnt;
      logic [7:0]  wr1, wr2;
      int          t;
      if (en_mode == 0) return;
      if (wait_cnt != 0) begin
        wait_cnt--;
        return;
      end
      t = regs[I_TIMA][1:0] + regs[I_TIMB][1:0];
      wait_cnt = (t >= 4) ? 3'd0 : 3'(4 - t);
      wr1 = regs[I_WR1];
      wr2 = regs[I_WR2];
      a = {regs[I_RR4], regs[I_RR3]};
      if (wr2[5]) b = {regs[I_BH], regs[I_BL]};
      else begin
        if ((regs[I_RR1] | regs[I_RR2]) == 0) begin
          regs[I_RR5] = regs[I_BL];
          regs[I_RR6] = regs[I_BH];
        end
        b = {regs[I_RR6], regs[I_RR5]};
      end
      r.transfer = 1'b1;
      if (regs[I_WR0][2]) begin
        r.source_address = a; r.source_is_io = wr1[3];
        r.dest_address   = b; r.dest_is_io   = wr2[3];
      end else begin
        r.source_address = b; r.source_is_io = wr2[3];
        r.dest_address   = a; r.dest_is_io   = wr1[3];
      end
      r.cycles_taken = 2'd2;
      cnt = {regs[I_RR2], regs[I_RR1]} + 16'd1;
      {regs[I_RR2], regs[I_RR1]} = cnt;
      {regs[I_RR4], regs[I_RR3]} = next_addr(a, wr1);
      if (!wr2[5]) {regs[I_RR6], regs[I_RR5]} = next_addr(b, wr2);
      n_moves++;
      if (regs[I_RR1] == regs[I_LENL] && regs[I_RR2] == regs[I_LENH]) begin
        en_mode = 2'd0;
        regs[I_RR0][0] = 1'b1;
        r.block_done = 1'b1;
        n_blocks++;
      end
    endfunction

    // one accepted transaction: advance the shadow state, queue its result
    function void note_command(action_t act, logic [7:0] data);
      result_t r;
      r = '0;
      case (act)
        ACT_WRITE: write_ctrl(data);
        ACT_READ:  begin
          r.read_data = read_status();
          n_reads++;
        end
        ACT_TICK:  bus_tick(r);
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want,
               n_results);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("result with nothing outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data != want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.transfer != want.transfer) report("transfer", got.transfer, want.transfer);
      if (got.source_address != want.source_address)
        report("source_address", got.source_address, want.source_address);
      if (got.source_is_io != want.source_is_io)
        report("source_is_io", got.source_is_io, want.source_is_io);
      if (got.dest_address != want.dest_address)
        report("dest_address", got.dest_address, want.dest_address);
      if (got.dest_is_io != want.dest_is_io) report("dest_is_io", got.dest_is_io, want.dest_is_io);
      if (got.cycles_taken != want.cycles_taken)
        report("cycles_taken", got.cycles_taken, want.cycles_taken);
      if (got.block_done != want.block_done) report("block_done", got.block_done, want.block_done);
      n_results++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  action_t     action;
  logic [7:0]  write_data;
  logic        done;
  logic [7:0]  read_data;
  logic        transfer;
  logic [15:0] source_address;
  logic        source_is_io;
  logic [15:0] dest_address;
  logic        dest_is_io;
  logic [1:0]  cycles_taken;
  logic        block_done;

  dma_scoreboard sb;
  int            n_sent;

  z80_dma_controller i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .write_data     (write_data),
    .done           (done),
    .read_data      (read_data),
    .transfer       (transfer),
    .source_address (source_address),
    .source_is_io   (source_is_io),
    .dest_address   (dest_address),
    .dest_is_io     (dest_is_io),
    .cycles_taken   (cycles_taken),
    .block_done     (block_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2400000;
    $display("timeout waiting for results");
    $display("tb failed");
    $finish;
  end

  // results are taken in their strobe cycle; the receiver never stalls
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{read_data, transfer, source_address, source_is_io, dest_address,
                        dest_is_io, cycles_taken, block_done});
  end

  // one transaction: optional idle gap, then hold start until busy is seen low
  task send(action_t act, logic [7:0] data);
    int  gap;
    logic b;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    write_data <= data;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
    sb.note_command(act, data);
    n_sent++;
  endtask

  task wr(logic [7:0] v);
    send(ACT_WRITE, v);
  endtask

  // a full block setup with random content, then ticks and reads until done
  task run_block();
    logic [7:0] v;
    int         len;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    wr(8'h79 | ($urandom_range(0, 1) ? 8'h04 : 8'h00) | 8'($urandom_range(0, 1) << 1));
    wr(8'($urandom)); wr(8'($urandom));
    wr(8'(len)); wr(8'h00);
    wr(8'h44 | (8'($urandom) & 8'h38));
    wr(8'($urandom));
    wr(8'h40 | (8'($urandom) & 8'h38));
    wr(8'($urandom));
    v = 8'h8D | (8'($urandom_range(0, 1)) << 4) | (8'($urandom) & 8'h60);
    wr(v);
    wr(8'($urandom)); wr(8'($urandom));
    if (v[4]) begin
      v = 8'($urandom);
      wr(v);
      if (v[3]) wr(8'($urandom));
      if (v[4]) wr(8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      v = 8'h80 | (8'($urandom) & 8'h18);
      wr(v);
      if (v[3]) wr(8'($urandom));
      if (v[4]) wr(8'($urandom));
    end
    wr(CMD_REINIT);
    if ($urandom_range(0, 2) == 0) wr(CMD_CLRCNT);
    if ($urandom_range(0, 3) == 0) wr($urandom_range(0, 1) ? CMD_TIMA : CMD_TIMB);
    case ($urandom_range(0, 2))
      0: wr(CMD_EN1);
      1: wr(CMD_EN2);
      default: wr(CMD_SETEN);
    endcase
    for (int k = 0; k < len * 5 + 4; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) begin
          wr(CMD_RDMSK); wr(8'($urandom)); wr(CMD_RDINIT);
        end else wr(CMD_RDST);
        repeat ($urandom_range(1, 4)) send(ACT_READ, 8'($urandom));
      end
      send(ACT_TICK, 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] directed [] = '{CMD_RESET, CMD_TIMA, CMD_TIMB, CMD_REINIT, CMD_CLRCNT,
                                CMD_CLRB5, CMD_SETB5, CMD_SETEN, CMD_EN2, CMD_RDST,
                                CMD_RDMSK, 8'hFF, CMD_RDINIT, CMD_EN1, CMD_DIS, 8'hB3,
                                8'h8B, 8'h00};
    sb = new();
    sb.clear_state();
    n_sent     = 0;
    rst        = 1'b1;
    start      = 1'b0;
    action     = ACT_NONE;
    write_data = 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, unused action, every command byte, data extremes
    send(ACT_READ, 8'h00);
    send(ACT_NONE, 8'hFF);
    foreach (directed[i]) wr(directed[i]);
    send(ACT_READ, 8'hFF);
    send(ACT_TICK, 8'h00);
    send(ACT_TICK, 8'hFF);

    // random: mostly well-formed blocks, with raw noise in between
    while (n_sent < 1950) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 8)) send(action_t'($urandom_range(0, 3)), 8'($urandom));
      else
        run_block();
    end

    // drop start right at the last accepting edge so nothing extra is taken
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d transactions: %0d byte moves, %0d blocks completed, %0d status reads",
             n_sent, sb.n_moves, sb.n_blocks, sb.n_reads);
    $display("%0d results checked, %0d mismatches", sb.n_results, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule
